/* hw/rtl/wrapped_texture_sampler_unit_assert.svh */
// Assertion macros shared by the texture sampler RTL.
`ifndef WRAPPED_TEXTURE_SAMPLER_UNIT_ASSERT_SVH
`define WRAPPED_TEXTURE_SAMPLER_UNIT_ASSERT_SVH

// Checked on every clock edge outside reset.
`define WTSU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, including while reset is held.
`define WTSU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/wtsu_pkg.sv */
// Package with types and constants of the texture sampler.
`timescale 1ns / 1ps
package wtsu_pkg;

  localparam int TEX_AW          = 16;
  localparam int MAX_TEXELS      = 65536;
  localparam int MAX_DIMENSION   = 256;
  localparam int DIM_W           = 9;
  localparam int XY_W            = 8;
  localparam int COORD_FRAC_BITS = 16;
  localparam int COORD_W         = 32;
  localparam int K_W             = 15;
  localparam int ITERS           = 15;
  localparam int SUM_W           = 18;
  localparam int ACC_W           = 52;
  localparam int B_W             = 34;
  localparam int TGT_SHIFT       = 30;
  localparam int Q14_ONE         = 16384;
  localparam int NORM_W          = 16;
  localparam int IN_DATA_W       = 104;
  localparam int OUT_DATA_W      = 72;
  localparam int CFG_IDX_W       = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL = 2'd2;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // One normal component while its magnitude is found bit by bit.
  typedef struct packed {
    logic [K_W-1:0]   k;
    logic [ACC_W-1:0] a;
    logic [B_W-1:0]   b;
    logic [15:0]      msq;
    logic             neg;
  } lane_t;

  typedef struct packed {
    logic              cmd;
    logic [TEX_AW-1:0] addr;
    logic [23:0]       rgb;
    logic [XY_W-1:0]   x;
    logic [XY_W-1:0]   y;
    logic [SUM_W-1:0]  sum;
    lane_t [2:0]       lane;
  } item_t;

  // Clamp a configured dimension into 1..MAX_DIMENSION.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    r = d;
    if (d == '0) r = DIM_W'(1);
    else if (d > DIM_W'(MAX_DIMENSION)) r = DIM_W'(MAX_DIMENSION);
    return r;
  endfunction

endpackage

/* hw/rtl/wtsu_norm_step.sv */
// One trial step of the normal magnitude search for a single component.
`timescale 1ns / 1ps
module wtsu_norm_step #(
  parameter int BIT = 0
) (
  input  wtsu_pkg::lane_t             lane_i,
  input  logic [wtsu_pkg::SUM_W-1:0]  sum_i,
  output wtsu_pkg::lane_t             lane_o
);
  import wtsu_pkg::*;

  logic [ACC_W-1:0] sum_w;
  logic [ACC_W-1:0] b_w;
  logic [ACC_W-1:0] c2;
  logic [ACC_W-1:0] cs;
  logic [ACC_W-1:0] trial;
  logic [ACC_W-1:0] target;

  // With candidate c = k + 2^BIT: c2 = c*c*sum, cs = c*sum, built by shifts only.
  assign sum_w  = ACC_W'(sum_i);
  assign b_w    = ACC_W'(lane_i.b);
  assign c2     = lane_i.a + (b_w << (BIT + 1)) + (sum_w << (2 * BIT));
  assign cs     = b_w + (sum_w << BIT);
  assign trial  = (c2 << 2) - (cs << 2) + sum_w;
  assign target = ACC_W'(lane_i.msq) << TGT_SHIFT;

  // Keep the bit when (2c-1)^2 * sum stays within the target.
  always_comb begin
    lane_o = lane_i;
    if (trial <= target) begin
      lane_o.k = lane_i.k | (K_W'(1) << BIT);
      lane_o.a = c2;
      lane_o.b = cs[B_W-1:0];
    end
  end

endmodule

/* hw/rtl/wrapped_texture_sampler_unit.sv */
// Top level of the repeat-wrap nearest-neighbor texture sampler.
`timescale 1ns / 1ps
// Texture sampler with repeat wrap. Write beats (tuser low) store an RGB texel
// at write_index; sample beats (tuser high) wrap u and v with period one, pick
// the texel at y*width+x and return its bytes, plus a Q1.14 unit normal when
// normal mode is set. Every beat returns exactly one result beat, write
// acknowledgements as all zeros. The block takes one beat per clock while the
// output is not stalled, and a result passes through these stages in order: two
// stages for wrap and address, one for the single-port texel memory, one for decode,
// fifteen for the bit-by-bit normal magnitude search and one output register. Each
// stage holds its own valid bit, so bubbles close up under back-pressure.
// Configuration writes are taken at any time but belong to idle periods.
module wrapped_texture_sampler_unit
  #(
  parameter int FRAC_BITS = wtsu_pkg::COORD_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // command
  input  logic                              in_tuser,
  // u_coord, v_coord, write_index, write_red, write_green, write_blue
  input  logic [wtsu_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // red, green, blue, normal_x, normal_y, normal_z
  output logic [wtsu_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wtsu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wtsu_pkg::DIM_W-1:0]        cfg_data
);
  import wtsu_pkg::*;

  `include "wrapped_texture_sampler_unit_assert.svh"

  localparam int N       = 20;
  localparam int ST_MEM  = 3;
  localparam int ST_DEC  = 4;
  localparam int ST_ITER = 5;
  localparam int PROD_W  = FRAC_BITS + DIM_W;

  logic [DIM_W-1:0] width_r, height_r;
  logic             normal_r;
  logic [DIM_W-1:0] w_use, h_use;

  logic [N:1]        v_r;
  logic [N:1]        en;
  item_t             pipe_r [1:N-1];
  item_t             st1_nxt, st2_nxt, st4_nxt;
  item_t             iter_nxt [ST_ITER:N-1];
  logic [23:0]       texel_r;
  logic [23:0]       mem [0:MAX_TEXELS-1];
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic              out_cmd_r;

  logic [PROD_W-1:0]          prod_u, prod_v;
  logic [2*DIM_W-1:0]         row_base;
  logic [NORM_W-1:0]          comp [0:2];
  logic [7:0]                 tb [0:2];
  logic [7:0]                 mag [0:2];
  logic [15:0]                msq [0:2];

  // Configuration registers.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(MAX_DIMENSION);
      height_r <= DIM_W'(MAX_DIMENSION);
      normal_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_data;
        REG_HEIGHT: height_r <= cfg_data;
        REG_NORMAL: normal_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign w_use = clamp_dim(width_r);
  assign h_use = clamp_dim(height_r);

  // Stage enables: a stage loads when it is empty or its content moves on.
  always_comb begin
    en[N] = !v_r[N] || out_tready;
    for (int i = N - 1; i >= 1; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end
  assign in_tready = en[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) v_r[1] <= in_tvalid;
      for (int i = 2; i <= N; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  // Stage 1: wrap u and v into texel columns and rows.
  assign prod_u = PROD_W'(in_tdata[FRAC_BITS-1:0]) * PROD_W'(w_use);
  assign prod_v = PROD_W'(in_tdata[COORD_W +: FRAC_BITS]) * PROD_W'(h_use);
  always_comb begin
    st1_nxt      = '0;
    st1_nxt.cmd  = in_tuser;
    st1_nxt.x    = prod_u[FRAC_BITS +: XY_W];
    st1_nxt.y    = prod_v[FRAC_BITS +: XY_W];
    st1_nxt.addr = in_tdata[2*COORD_W +: TEX_AW];
    st1_nxt.rgb  = in_tdata[2*COORD_W + TEX_AW +: 24];
  end

  // Stage 2: linear address, taken modulo the store size.
  assign row_base = (2*DIM_W)'(pipe_r[1].y) * (2*DIM_W)'(w_use)
                  + (2*DIM_W)'(pipe_r[1].x);
  always_comb begin
    st2_nxt = pipe_r[1];
    if (pipe_r[1].cmd == CMD_SAMPLE) st2_nxt.addr = row_base[TEX_AW-1:0];
  end

  // Pipeline data registers; the valid bits travel alongside in v_r.
  always_ff @(posedge clk) begin
    if (en[1]) pipe_r[1] <= st1_nxt;
    if (en[2]) pipe_r[2] <= st2_nxt;
    if (en[ST_MEM]) pipe_r[ST_MEM] <= pipe_r[2];
    if (en[ST_DEC]) pipe_r[ST_DEC] <= st4_nxt;
    for (int s = ST_ITER; s <= N - 1; s++) begin
      if (en[s]) pipe_r[s] <= iter_nxt[s];
    end
  end

  // Stage 3: texel memory, one write or one read per beat in order.
  always_ff @(posedge clk) begin
    if (en[ST_MEM] && v_r[2] && pipe_r[2].cmd == CMD_WRITE) begin
      mem[pipe_r[2].addr] <= pipe_r[2].rgb;
    end
  end
  always_ff @(posedge clk) begin
    if (en[ST_MEM]) texel_r <= mem[pipe_r[2].addr];
  end

  // Stage 4: signed components 2t-255, their squares and the squared length.
  always_comb begin
    st4_nxt     = pipe_r[ST_MEM];
    st4_nxt.rgb = (pipe_r[ST_MEM].cmd == CMD_SAMPLE) ? texel_r : 24'd0;
    for (int c = 0; c < 3; c++) begin
      tb[c]  = st4_nxt.rgb[8*c +: 8];
      mag[c] = tb[c][7] ? 8'({tb[c], 1'b0} - 9'd255) : 8'(9'd255 - {tb[c], 1'b0});
      msq[c] = 16'(mag[c]) * 16'(mag[c]);
      st4_nxt.lane[c]     = '0;
      st4_nxt.lane[c].msq = msq[c];
      st4_nxt.lane[c].neg = !tb[c][7];
    end
    st4_nxt.sum = SUM_W'(msq[0]) + SUM_W'(msq[1]) + SUM_W'(msq[2]);
  end

  // Stages 5 to 19: one magnitude bit per stage, most significant first.
  for (genvar s = ST_ITER; s <= N - 1; s++) begin : g_iter
    for (genvar c = 0; c < 3; c++) begin : g_lane
      wtsu_norm_step #(.BIT(N - 1 - s)) u_step (
        .lane_i (pipe_r[s-1].lane[c]),
        .sum_i  (pipe_r[s-1].sum),
        .lane_o (iter_nxt[s].lane[c])
      );
    end
    assign iter_nxt[s].cmd  = pipe_r[s-1].cmd;
    assign iter_nxt[s].addr = pipe_r[s-1].addr;
    assign iter_nxt[s].rgb  = pipe_r[s-1].rgb;
    assign iter_nxt[s].x    = pipe_r[s-1].x;
    assign iter_nxt[s].y    = pipe_r[s-1].y;
    assign iter_nxt[s].sum  = pipe_r[s-1].sum;
  end

  // Stage 20: sign the components and pack the result beat.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      comp[c] = pipe_r[N-1].lane[c].neg ? NORM_W'(-{1'b0, pipe_r[N-1].lane[c].k})
                                        : NORM_W'({1'b0, pipe_r[N-1].lane[c].k});
      if (!(normal_r && pipe_r[N-1].cmd == CMD_SAMPLE)) comp[c] = '0;
    end
    out_data_nxt = {comp[2], comp[1], comp[0], pipe_r[N-1].rgb};
  end

  always_ff @(posedge clk) begin
    if (en[N]) begin
      out_data_r <= out_data_nxt;
      out_cmd_r  <= pipe_r[N-1].cmd;
    end
  end

  assign out_tvalid = v_r[N];
  assign out_tdata  = out_data_r;

  // A write acknowledgement carries only zeros.
  `WTSU_ASSERT(a_write_ack_zero, v_r[N] && out_cmd_r == CMD_WRITE |-> out_data_r == '0, "write acknowledgement not zero")
  // The search never passes one in Q1.14.
  `WTSU_ASSERT(a_norm_bound, v_r[N-1] |-> pipe_r[N-1].lane[0].k <= K_W'(Q14_ONE) && pipe_r[N-1].lane[1].k <= K_W'(Q14_ONE) && pipe_r[N-1].lane[2].k <= K_W'(Q14_ONE), "normal magnitude above one")
  // Reset empties the pipeline.
  `WTSU_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> v_r == '0, "pipeline not empty after reset")

endmodule
